/* sv/bis_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary insertion sorter package
// Shared constants for the sorter top level and its sorted store.
// ----------------------------------------------------------------------------
package bis_pkg;

  // Default capacity of the sorted store, in entries.
  localparam int CAPACITY_DEF = 64;

  // Default width of a stored value, in bits.
  localparam int VALUE_WIDTH_DEF = 32;

  // Width of the value on the ports.
  localparam int IO_WIDTH = 32;

  // Widest stored value supported; used as a common extension width.
  localparam int WIDE_WIDTH = 64;

endpackage : bis_pkg

/* sv/bis_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted store
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module bis_store #(
  parameter int DEPTH = bis_pkg::CAPACITY_DEF,
  parameter int WIDTH = bis_pkg::VALUE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule : bis_store

/* sv/binary_insertion_sorter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary insertion sorter
// Collects signed values into an ascending, stable sorted store and emits
// the whole set in order when a value marked last arrives.
// ----------------------------------------------------------------------------
// Each input transaction carries one value. The unit finds the insertion
// point with a binary search over the filled part of the store (each probe
// is one memory read and one compare), then moves every larger entry up by
// one place (one read and one write per moved entry on the single-ported
// store), and finally writes the new value. in_stall is high from the
// search through the write of the new value, and through the emission of
// a set. Equal values keep their arrival order. A value that arrives while
// the store is full is accepted without a search and is not stored.
// A transaction with last_in set is inserted as well, after which the set is
// emitted in ascending order, each entry read and then loaded into the
// output register once it is free, with last_out on the final one. The store
// is then empty and the next set may start while the final result still
// waits in the output register. Values arriving while the store is full are
// dropped, and every output transaction of that set carries overflow.
// ----------------------------------------------------------------------------
module binary_insertion_sorter_unit #(
  parameter int CAPACITY    = bis_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bis_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [bis_pkg::IO_WIDTH-1:0] value,
  input  logic                                last_in,
  // Output channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bis_pkg::IO_WIDTH-1:0] sorted_value,
  output logic                                last_out,
  output logic                                overflow
);

  import bis_pkg::*;

  // Address width of the store and width of a count that can reach CAPACITY.
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an input transaction
  localparam logic [2:0] S_SRCH = 3'd1;  // issue read of the middle entry
  localparam logic [2:0] S_CMP  = 3'd2;  // compare and narrow the range
  localparam logic [2:0] S_SHRD = 3'd3;  // read the entry below the gap
  localparam logic [2:0] S_SHWR = 3'd4;  // write it one place up
  localparam logic [2:0] S_INS  = 3'd5;  // write the new value into the gap
  localparam logic [2:0] S_EMRD = 3'd6;  // read the next entry to emit
  localparam logic [2:0] S_EMLD = 3'd7;  // load it into the output register

  logic [2:0]             state, state_next;
  logic [CW-1:0]          lo, lo_next;
  logic [CW-1:0]          hi, hi_next;
  logic [CW-1:0]          idx, idx_next;       // shift or emit position
  logic [CW-1:0]          fill, fill_next;
  logic                   dropped, dropped_next;
  logic [VALUE_WIDTH-1:0] val, val_next;
  logic                   last, last_next;

  logic                   out_valid_next;
  logic [IO_WIDTH-1:0]    sorted_value_next;
  logic                   last_out_next;
  logic                   overflow_next;

  logic [CW-1:0]          mid;
  logic [CW-1:0]          idx_dec;
  logic                   in_take;
  logic                   out_free;
  logic                   key_less;

  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [AW-1:0]          rd_addr;
  logic [VALUE_WIDTH-1:0] rd_data;

  logic [WIDE_WIDTH-1:0]  value_wide;
  logic [WIDE_WIDTH-1:0]  rd_wide;

  bis_store #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The port value is sign-extended and then cut to the stored width; a
  // stored value is zero-extended or cut to the port width on the way out.
  assign value_wide = WIDE_WIDTH'(value);
  assign rd_wide    = WIDE_WIDTH'(rd_data);

  assign mid      = lo + ((hi - lo) >> 1);
  assign idx_dec  = idx - CW'(1);
  assign key_less = $signed(val) < $signed(rd_data);

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid || !out_stall;

  // Read address follows the phase; it is held while a result waits so the
  // registered read data stays put.
  always_comb begin
    unique case (state)
      S_SHRD, S_SHWR: rd_addr = idx_dec[AW-1:0];
      S_EMRD, S_EMLD: rd_addr = idx[AW-1:0];
      default:        rd_addr = mid[AW-1:0];
    endcase
  end

  // Single write port: moved entries during the shift, the new value last.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = rd_data;
    if (state == S_SHWR) begin
      wr_en = 1'b1;
    end else if (state == S_INS) begin
      wr_en   = 1'b1;
      wr_addr = lo[AW-1:0];
      wr_data = val;
    end
  end

  always_comb begin
    state_next        = state;
    lo_next           = lo;
    hi_next           = hi;
    idx_next          = idx;
    fill_next         = fill;
    dropped_next      = dropped;
    val_next          = val;
    last_next         = last;
    out_valid_next    = out_valid && out_stall;
    sorted_value_next = sorted_value;
    last_out_next     = last_out;
    overflow_next     = overflow;

    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          val_next  = value_wide[VALUE_WIDTH-1:0];
          last_next = last_in;
          if (fill == CW'(CAPACITY)) begin
            // Store full: the value is dropped, the set is still emitted.
            dropped_next = 1'b1;
            idx_next     = '0;
            if (last_in) begin
              state_next = S_EMRD;
            end
          end else begin
            lo_next    = '0;
            hi_next    = fill;
            state_next = S_SRCH;
          end
        end
      end

      S_SRCH: begin
        if (lo < hi) begin
          state_next = S_CMP;
        end else begin
          idx_next   = fill;
          state_next = S_SHRD;
        end
      end

      S_CMP: begin
        // Find the first entry strictly greater than the new value.
        if (key_less) begin
          hi_next = mid;
        end else begin
          lo_next = mid + CW'(1);
        end
        state_next = S_SRCH;
      end

      S_SHRD: begin
        if (idx > lo) begin
          state_next = S_SHWR;
        end else begin
          state_next = S_INS;
        end
      end

      S_SHWR: begin
        idx_next   = idx_dec;
        state_next = S_SHRD;
      end

      S_INS: begin
        fill_next = fill + CW'(1);
        idx_next  = '0;
        if (last) begin
          state_next = S_EMRD;
        end else begin
          state_next = S_IDLE;
        end
      end

      S_EMRD: begin
        state_next = S_EMLD;
      end

      S_EMLD: begin
        if (out_free) begin
          out_valid_next    = 1'b1;
          sorted_value_next = rd_wide[IO_WIDTH-1:0];
          last_out_next     = (idx + CW'(1) == fill);
          overflow_next     = dropped;
          if (idx + CW'(1) == fill) begin
            // Final result loaded: the store is empty for the next set.
            fill_next    = '0;
            dropped_next = 1'b0;
            state_next   = S_IDLE;
          end else begin
            idx_next   = idx + CW'(1);
            state_next = S_EMRD;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      dropped   <= dropped_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    lo           <= lo_next;
    hi           <= hi_next;
    idx          <= idx_next;
    val          <= val_next;
    last         <= last_next;
    sorted_value <= sorted_value_next;
    last_out     <= last_out_next;
    overflow     <= overflow_next;
  end

endmodule : binary_insertion_sorter_unit
